[rtl/es2cal_pkg.sv]
// Constants and month table for the epoch seconds to calendar converter.
package es2cal_pkg;

  localparam int unsigned SecondsPerDay = 86400;
  localparam int unsigned SecondsPerHour = 3600;

  // Reciprocals: floor(x / d) = (x * M) >> K over the ranges used here.
  localparam logic [25:0] DayRecip = 26'd50903317;   // (secs >> 7) / 675, K = 35
  localparam logic [12:0] HourRecip = 13'd4661;      // (tod >> 4) / 225, K = 20
  localparam logic [16:0] WeekRecip = 17'd74899;     // x / 7, K = 19
  localparam logic [16:0] QuadRecip = 17'd91868;     // x / 1461, K = 27
  localparam logic [12:0] MinRecip = 13'd4370;       // x / 60, K = 18

  // Day count is rebased to 1968-01-01 so that each 1461-day block opens on a leap year.
  localparam logic [15:0] RebaseDays = 16'd731;
  // First day (from 1970) past 2100-02-28; 2100 is not a leap year.
  localparam logic [15:0] SkipDay2100 = 16'd47541;
  localparam logic [7:0] Year2100 = 8'd200;
  localparam logic [7:0] RebaseYear = 8'd68;

  // Zero-based day of year on which month m starts.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    logic [8:0] adj;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    adj = (leap && (m >= 4'd2)) ? 9'd1 : 9'd0;
    return base + adj;
  endfunction

endpackage

[rtl/epoch_seconds_to_calendar_core.sv]
// Seven-stage pipelined converter from epoch seconds to UTC calendar fields.
// Throughput: one transaction per cycle; each stage holds while the one
//   after it is full and stalled, and bubbles collapse.
// Reset: rst (synchronous) clears every stage valid; payload registers keep
//   whatever they hold.
// Divisions by constants are reciprocal multiplies spread over the stages.
module epoch_seconds_to_calendar_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [7:0]  years_since_1900,
  output logic [8:0]  day_of_year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month
);
  import es2cal_pkg::*;

  // Stage valids; out_valid is stage 7.
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  // A stage may load when empty or when its content moves on this cycle.
  assign rdy7 = !out_valid || !out_stall;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
      if (rdy7) out_valid <= v6;
    end
  end

  // ---- Stage 1: day quotient product, 86400 = 128 * 675 ----
  logic [31:0] s1_secs;
  logic [50:0] s1_prod;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_secs <= epoch_seconds;
      s1_prod <= 51'(epoch_seconds[31:7]) * 51'(DayRecip);
    end
  end

  // ---- Stage 2: whole days and time of day ----
  logic [15:0] days_c;
  logic [31:0] day_secs_c;
  logic [15:0] s2_days;
  logic [16:0] s2_tod;

  assign days_c = s1_prod[50:35];
  assign day_secs_c = 32'(days_c) * 32'(SecondsPerDay);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_days <= days_c;
      s2_tod  <= 17'(s1_secs - day_secs_c);
    end
  end

  // ---- Stage 3: products for hour, weekday and four-year block ----
  // Past Feb 28 2100 one day is added so that 2100 looks like a leap year;
  // stage 6 takes it back out of the day of year.
  logic [15:0] dp_c;
  logic [16:0] wk_c;
  logic [15:0] s3_days;
  logic [16:0] s3_tod;
  logic [15:0] s3_dp;
  logic [25:0] s3_ph;
  logic [33:0] s3_pw;
  logic [32:0] s3_pq;

  assign dp_c = s2_days + RebaseDays + 16'(s2_days >= SkipDay2100);
  assign wk_c = 17'(s2_days) + 17'd4;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_days <= s2_days;
      s3_tod  <= s2_tod;
      s3_dp   <= dp_c;
      s3_ph   <= 26'(s2_tod[16:4]) * 26'(HourRecip);
      s3_pw   <= 34'(wk_c) * 34'(WeekRecip);
      s3_pq   <= 33'(dp_c) * 33'(QuadRecip);
    end
  end

  // ---- Stage 4: hour, seconds in hour, weekday, block and offset ----
  logic [4:0]  hour_c;
  logic [16:0] q7_c;
  logic [5:0]  q4_c;
  logic [16:0] wk4_c;
  logic [4:0]  s4_hour;
  logic [11:0] s4_remh;
  logic [2:0]  s4_wd;
  logic [5:0]  s4_q4;
  logic [10:0] s4_r;

  assign hour_c = s3_ph[24:20];
  assign q7_c = 17'(s3_pw[33:19]);
  assign q4_c = s3_pq[32:27];
  assign wk4_c = 17'(s3_days) + 17'd4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_hour <= hour_c;
      s4_remh <= 12'(s3_tod - 17'(hour_c) * 17'(SecondsPerHour));
      s4_wd   <= 3'(wk4_c - q7_c * 17'd7);
      s4_q4   <= q4_c;
      s4_r    <= 11'(s3_dp - 16'(q4_c) * 16'd1461);
    end
  end

  // ---- Stage 5: minute, year within block, day of year ----
  logic [10:0] r2_c;
  logic [1:0]  yoff_c;
  logic [8:0]  doy_c;
  logic [24:0] pm_c;
  logic [4:0]  s5_hour;
  logic [11:0] s5_remh;
  logic [2:0]  s5_wd;
  logic [5:0]  s5_min;
  logic [7:0]  s5_year;
  logic [8:0]  s5_doy;
  logic        s5_leap;

  assign pm_c = 25'(s4_remh) * 25'(MinRecip);

  always_comb begin
    r2_c = s4_r - 11'd366;
    if (s4_r < 11'd366) begin
      yoff_c = 2'd0;
      doy_c = s4_r[8:0];
    end else if (r2_c < 11'd365) begin
      yoff_c = 2'd1;
      doy_c = r2_c[8:0];
    end else if (r2_c < 11'd730) begin
      yoff_c = 2'd2;
      doy_c = 9'(r2_c - 11'd365);
    end else begin
      yoff_c = 2'd3;
      doy_c = 9'(r2_c - 11'd730);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_hour <= s4_hour;
      s5_remh <= s4_remh;
      s5_wd   <= s4_wd;
      s5_min  <= pm_c[23:18];
      s5_year <= RebaseYear + {s4_q4, 2'b00} + 8'(yoff_c);
      s5_doy  <= doy_c;
      s5_leap <= (yoff_c == 2'd0);
    end
  end

  // ---- Stage 6: second, 2100 correction ----
  logic        y2100_c;
  logic [4:0]  s6_hour;
  logic [2:0]  s6_wd;
  logic [5:0]  s6_min;
  logic [5:0]  s6_sec;
  logic [7:0]  s6_year;
  logic [8:0]  s6_doy;
  logic        s6_leap;

  assign y2100_c = (s5_year == Year2100);

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_hour <= s5_hour;
      s6_wd   <= s5_wd;
      s6_min  <= s5_min;
      s6_sec  <= 6'(s5_remh - 12'(s5_min) * 12'd60);
      s6_year <= s5_year;
      s6_doy  <= (y2100_c && s5_doy >= 9'd60) ? s5_doy - 9'd1 : s5_doy;
      s6_leap <= s5_leap && !y2100_c;
    end
  end

  // ---- Stage 7: month by parallel compare against month starts ----
  logic [3:0] mon_c;

  always_comb begin
    mon_c = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s6_doy >= month_start(s6_leap, 4'(m))) mon_c = 4'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      second           <= s6_sec;
      minute           <= s6_min;
      hour             <= s6_hour;
      weekday          <= s6_wd;
      years_since_1900 <= s6_year;
      day_of_year      <= s6_doy;
      month            <= mon_c;
      day_of_month     <= 5'(s6_doy - month_start(s6_leap, mon_c) + 9'd1);
    end
  end

`ifndef SYNTHESIS
  // Time-of-day split must land in range.
  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weekday < 3'd7) && (month < 4'd12) && (day_of_month != 5'd0))
    else $error("date field out of range");

  // A transaction taken at the input must show up at stage 1.
  a_stage1_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted transaction lost at stage 1");
`endif

endmodule

[verif/tb_top.sv]
// Testbench for the epoch seconds to UTC calendar converter: directed table plus random stimulus.
module tb_top;
  import es2cal_pkg::*;

  // Broken-down calendar time, one per output transaction.
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;
  } cal_t;

  // One directed row: input, and optionally a hand-written expectation.
  typedef struct {
    logic [31:0] secs;
    bit          has_fixed;
    cal_t        fixed;
  } row_t;

  localparam int NumRandom = 1630;
  localparam int DrainCycles = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [2:0]  weekday;
  logic [7:0]  years_since_1900;
  logic [8:0]  day_of_year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;

  cal_t pending_dates[$];   // expected calendar results, oldest first
  int   mismatch_count = 0;
  bit   calm_mode = 1'b0;   // long stretch with no idling on either side

  epoch_seconds_to_calendar_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .epoch_seconds(epoch_seconds),
    .out_valid(out_valid), .out_stall(out_stall),
    .second(second), .minute(minute), .hour(hour), .weekday(weekday),
    .years_since_1900(years_since_1900), .day_of_year(day_of_year),
    .month(month), .day_of_month(day_of_month)
  );

  always #5 clk = ~clk;

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Gregorian breakdown by straight year and month subtraction.
  function automatic cal_t gmtime_of(logic [31:0] secs);
    int unsigned tod, days, yr, mon, mlen;
    cal_t c;
    tod = secs % 86400;
    days = secs / 86400;
    yr = 1970;
    mon = 0;
    c.second = 6'(tod % 60);
    c.minute = 6'((tod % 3600) / 60);
    c.hour = 5'(tod / 3600);
    c.weekday = 3'((days + 4) % 7);
    while (days >= (leap_year(yr) ? 366 : 365)) begin
      days -= leap_year(yr) ? 366 : 365;
      yr++;
    end
    c.years_since_1900 = 8'(yr - 1900);
    c.day_of_year = 9'(days);
    forever begin
      case (mon)
        1: mlen = leap_year(yr) ? 29 : 28;
        3, 5, 8, 10: mlen = 30;
        default: mlen = 31;
      endcase
      if (mon >= 11 || days < mlen) break;
      days -= mlen;
      mon++;
    end
    c.month = 4'(mon);
    c.day_of_month = 5'(days + 1);
    return c;
  endfunction

  function automatic bit idle_now();
    return !calm_mode && ($urandom_range(99) < 34);
  endfunction

  // Present one transaction and hold it until accepted; called at a falling edge.
  task automatic send_seconds(logic [31:0] secs, cal_t want);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    epoch_seconds <= secs;
    pending_dates.push_back(want);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Random seconds, weighted toward interesting calendar spots.
  function automatic logic [31:0] pick_seconds();
    int unsigned yr, d;
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'hFFFF_FFFF, 32'hFFF0_0000);
      2: begin
        // around 2100-02-28 / 03-01 (non-leap century)
        d = 47541 + $urandom_range(4) - 2;
        return d * 86400 + $urandom_range(86399);
      end
      3: begin
        // around a year boundary
        yr = $urandom_range(2105, 1971);
        d = 0;
        for (int unsigned y = 1970; y < yr; y++) d += leap_year(y) ? 366 : 365;
        return (d * 86400) + $urandom_range(86400 * 2) - 86400;
      end
      default: return $urandom_range(86400 * 400);
    endcase
  endfunction

  // Output side: random stall, compare against the oldest expectation.
  always @(negedge clk) begin
    if (!rst) out_stall <= idle_now();
  end

  always @(posedge clk) begin
    cal_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{second, minute, hour, weekday, years_since_1900, day_of_year,
              month, day_of_month};
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected output transaction %p", got);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    cal_t want;
    rows.push_back('{32'd0, 1'b1, '{0, 0, 0, 4, 70, 0, 0, 1}});
    rows.push_back('{32'hFFFF_FFFF, 1'b1, '{15, 28, 6, 0, 206, 37, 1, 7}});
    rows.push_back('{32'd86399, 1'b1, '{59, 59, 23, 4, 70, 0, 0, 1}});
    rows.push_back('{32'd86400, 1'b1, '{0, 0, 0, 5, 70, 1, 0, 2}});
    rows.push_back('{32'd31535999, 1'b1, '{59, 59, 23, 4, 70, 364, 11, 31}});
    rows.push_back('{32'd31536000, 1'b1, '{0, 0, 0, 5, 71, 0, 0, 1}});
    rows.push_back('{32'd68169600, 1'b0, '0});   // 1972-02-29, leap day
    rows.push_back('{32'd94694399, 1'b0, '0});   // last second of leap year 1972
    rows.push_back('{32'd951782400, 1'b0, '0});  // 2000-02-29, divisible by 400
    rows.push_back('{32'd978220800, 1'b0, '0});  // 2000-12-31
    rows.push_back('{32'd4107542399, 1'b0, '0}); // 2100-02-28 end
    rows.push_back('{32'd4107542400, 1'b0, '0}); // 2100-03-01, no leap day
    rows.push_back('{32'h8000_0000, 1'b0, '0});
    rows.push_back('{32'h7FFF_FFFF, 1'b0, '0});
    rows.push_back('{32'hAAAA_AAAA, 1'b0, '0});
    rows.push_back('{32'h5555_5555, 1'b0, '0});
    rows.push_back('{32'd2678399, 1'b0, '0});    // end of January
    rows.push_back('{32'd5097599, 1'b0, '0});    // end of February 1970

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      want = rows[i].has_fixed ? rows[i].fixed : gmtime_of(rows[i].secs);
      send_seconds(rows[i].secs, want);
    end
    in_valid <= 1'b0;
    // Hold off until the pipe has fully drained.
    while (pending_dates.size() != 0) @(negedge clk);

    for (int i = 0; i < NumRandom; i++) begin
      logic [31:0] s;
      calm_mode = (i >= 600 && i < 800);
      s = pick_seconds();
      send_seconds(s, gmtime_of(s));
    end
    in_valid <= 1'b0;
    calm_mode = 1'b0;

    while (pending_dates.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/es2cal_pkg.sv
rtl/epoch_seconds_to_calendar_core.sv
verif/tb_top.sv
